>>> rtl/sbpr_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the slotted bus packet receiver.
// No dependencies; the front, queue, back and top files refer to it by scoped names.
package sbpr_pkg;

    // Payload buffer depth and decoupling queue depth
    localparam int BUFFER_DEPTH = 256;
    localparam int QUEUE_DEPTH  = 2;

    // Request operations, coded as the mode field of an input request
    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SLOT_MAP    = 2'd0,
        CFG_FIRST_FRAME = 2'd1,
        CFG_FRAME_COUNT = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    // Classified request as it travels from front to back
    typedef struct packed {
        op_t        op;
        logic [7:0] value;   // bus byte, or buffer index for a read
        logic       owned;   // slot map owns the byte taken as a type
    } entry_t;

endpackage

>>> rtl/sbpr_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces of the slotted bus packet receiver: requests in,
// results out and configuration writes. Valid/ready handshake on each.
interface sbpr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic [7:0] read_index;

    modport source (output valid, output mode, output rx_byte, output read_index,
                    input ready);
    modport sink (input valid, input mode, input rx_byte, input read_index,
                  output ready);
endinterface

interface sbpr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] phase;
    logic       packet_ready;
    logic       active_request;
    logic [7:0] packet_kind;
    logic [7:0] payload_len;
    logic       in_band;
    logic [7:0] read_data;

    modport source (output valid, output phase, output packet_ready,
                    output active_request, output packet_kind, output payload_len,
                    output in_band, output read_data, input ready);
    modport sink (input valid, input phase, input packet_ready,
                  input active_request, input packet_kind, input payload_len,
                  input in_band, input read_data, output ready);
endinterface

interface sbpr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/sbpr_front.sv
`timescale 1ns / 1ps
// Front end: holds the configuration registers, accepts requests and
// classifies them (operation, operand, slot ownership). Uses sbpr_pkg, sbpr_ifs.
module sbpr_front (
    input  logic            clk,
    input  logic            rst_n,
    sbpr_in_if.sink         item_in,
    sbpr_cfg_if.sink        cfg,
    output logic            push_valid,
    output sbpr_pkg::entry_t push_entry,
    input  logic            push_ready
);

    logic [63:0] slot_map_reg;
    logic [2:0]  first_frame_reg;
    logic [3:0]  frame_count_reg;

    logic [2:0]  frame_num;
    logic [2:0]  frame_idx;
    logic        owned;
    sbpr_pkg::op_t op;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_map_reg    <= '0;
            first_frame_reg <= '0;
            frame_count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (sbpr_pkg::cfg_index_t'(cfg.index))
                sbpr_pkg::CFG_SLOT_MAP:    slot_map_reg    <= cfg.data;
                sbpr_pkg::CFG_FIRST_FRAME: first_frame_reg <= cfg.data[2:0];
                sbpr_pkg::CFG_FRAME_COUNT: frame_count_reg <= cfg.data[3:0];
                default: ;
            endcase
        end
    end

    // Look up the slot owned by the byte if it turns out to be a type byte
    assign frame_num = item_in.rx_byte[2:0];
    assign frame_idx = frame_num - first_frame_reg;
    assign owned     = (frame_num >= first_frame_reg)
                     && ({1'b0, frame_idx} < frame_count_reg)
                     && slot_map_reg[{frame_idx, item_in.rx_byte[5:3]}];

    // Classify and hand to the queue
    assign op = sbpr_pkg::op_t'(item_in.mode);

    always_comb
    begin
        push_entry.op    = op;
        push_entry.owned = owned;
        unique case (op)
            sbpr_pkg::OP_READ: push_entry.value = item_in.read_index;
            default:           push_entry.value = item_in.rx_byte;
        endcase
    end

    assign push_valid    = item_in.valid;
    assign item_in.ready = push_ready;

endmodule

>>> rtl/sbpr_queue.sv
`timescale 1ns / 1ps
// Short queue between front and back so each side can stall on its own.
// Depth from sbpr_pkg::QUEUE_DEPTH; entries are sbpr_pkg::entry_t.
module sbpr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  sbpr_pkg::entry_t push_entry,
    output logic             push_ready,
    output logic             pop_valid,
    output sbpr_pkg::entry_t pop_entry,
    input  logic             pop
);

    localparam int DEPTH = sbpr_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    sbpr_pkg::entry_t entries [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

>>> rtl/sbpr_back.sv
`timescale 1ns / 1ps
// Back end: frame state machine, payload buffer and result register.
// Takes classified requests from sbpr_queue; uses sbpr_pkg and sbpr_ifs.
module sbpr_back #(
    parameter int BUFFER_DEPTH = sbpr_pkg::BUFFER_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  sbpr_pkg::entry_t q_entry,
    output logic             pop,
    sbpr_out_if.source       result_out
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [8:0] DEPTH_LIM = 9'(BUFFER_DEPTH);
    localparam logic [7:0] LEN_HDR   = 8'd3;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TYPE  = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_READY = 3'd4,
        PH_INUSE = 3'd5
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] kind_reg, kind_next;
    logic [7:0] exp_reg, exp_next;
    logic [7:0] wpos_reg, wpos_next;
    logic       inband_reg, inband_next;

    logic       out_valid_reg;
    phase_t     out_phase_reg;
    logic       out_ready_flag_reg;
    logic       out_req_reg;
    logic [7:0] rd_reg;

    logic [7:0] mem [BUFFER_DEPTH];

    logic       advance;
    logic       waiting;
    logic [7:0] len_val;
    logic [7:0] wpos_inc;
    logic       ready_flag;
    logic       req_flag;
    logic       mem_we;
    logic       rd_hit;

    // Take the next request when the result register is free or draining
    assign advance = q_valid && (!out_valid_reg || result_out.ready);
    assign pop     = advance;

    assign waiting  = (phase_reg == PH_READY) || (phase_reg == PH_INUSE);
    assign len_val  = kind_reg[7] ? q_entry.value : {1'b0, q_entry.value[6:0]};
    assign wpos_inc = wpos_reg + 8'd1;
    assign rd_hit   = (q_entry.op == sbpr_pkg::OP_READ)
                    && ({1'b0, q_entry.value} < DEPTH_LIM);

    // Frame state update for one request
    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        exp_next    = exp_reg;
        wpos_next   = wpos_reg;
        inband_next = inband_reg;
        ready_flag  = 1'b0;
        req_flag    = 1'b0;
        mem_we      = 1'b0;
        unique case (q_entry.op)
            sbpr_pkg::OP_BYTE:
            begin
                priority if (waiting)
                begin
                    // packet waiting: drop the byte
                end
                else if (q_entry.value == 8'h00)
                begin
                    phase_next = PH_TYPE;
                end
                else if (phase_reg == PH_TYPE)
                begin
                    kind_next  = q_entry.value;
                    phase_next = PH_LEN;
                    if (!q_entry.value[7])
                    begin
                        if (q_entry.owned)
                        begin
                            req_flag = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                else if (phase_reg == PH_LEN)
                begin
                    inband_next = !kind_reg[7] && q_entry.value[7];
                    priority if (len_val < LEN_HDR)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (len_val == LEN_HDR)
                    begin
                        exp_next   = '0;
                        phase_next = PH_READY;
                        ready_flag = 1'b1;
                    end
                    else
                    begin
                        exp_next   = len_val - LEN_HDR;
                        wpos_next  = '0;
                        phase_next = PH_DATA;
                    end
                end
                else if (phase_reg == PH_DATA)
                begin
                    mem_we    = ({1'b0, wpos_reg} < DEPTH_LIM);
                    wpos_next = wpos_inc;
                    if (wpos_inc >= exp_reg)
                    begin
                        phase_next = PH_READY;
                        ready_flag = 1'b1;
                    end
                end
                else
                begin
                    // idle: drop nonzero bytes
                end
            end
            sbpr_pkg::OP_RELEASE:
            begin
                if (waiting)
                begin
                    phase_next = PH_IDLE;
                end
            end
            sbpr_pkg::OP_READ:
            begin
                if (phase_reg == PH_READY)
                begin
                    phase_next = PH_INUSE;
                end
            end
            default: ;
        endcase
    end

    // Payload buffer: write payload bytes, register read data
    always_ff @(posedge clk)
    begin
        if (advance && mem_we)
        begin
            mem[wpos_reg[AW-1:0]] <= q_entry.value;
        end
        if (advance)
        begin
            rd_reg <= rd_hit ? mem[q_entry.value[AW-1:0]] : 8'h00;
        end
    end

    // Hold frame state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            kind_reg           <= '0;
            exp_reg            <= '0;
            wpos_reg           <= '0;
            inband_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_phase_reg      <= PH_IDLE;
            out_ready_flag_reg <= 1'b0;
            out_req_reg        <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            kind_reg           <= kind_next;
            exp_reg            <= exp_next;
            wpos_reg           <= wpos_next;
            inband_reg         <= inband_next;
            out_valid_reg      <= 1'b1;
            out_phase_reg      <= phase_next;
            out_ready_flag_reg <= ready_flag;
            out_req_reg        <= req_flag;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Kind, length and in-band flag only change when the result is loaded
    assign result_out.valid          = out_valid_reg;
    assign result_out.phase          = out_phase_reg;
    assign result_out.packet_ready   = out_ready_flag_reg;
    assign result_out.active_request = out_req_reg;
    assign result_out.packet_kind    = kind_reg;
    assign result_out.payload_len    = exp_reg;
    assign result_out.in_band        = inband_reg;
    assign result_out.read_data      = rd_reg;

`ifndef SYNTHESIS
    a_data_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (exp_reg != 8'd0))
        else $error("payload phase with zero expected length");

    a_data_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (wpos_reg < exp_reg))
        else $error("write position reached expected length in payload phase");

    a_ready_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready_flag_reg) |-> (out_phase_reg == PH_READY))
        else $error("completed packet not reported in ready phase");

    a_request_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_req_reg) |-> (out_phase_reg == PH_LEN && !kind_reg[7]))
        else $error("reply request without an active type awaiting length");

    a_result_mirrors_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_phase_reg == phase_reg))
        else $error("result phase differs from frame state");
`endif

endmodule

>>> rtl/slotted_bus_packet_receiver.sv
`timescale 1ns / 1ps
// Top level of the slotted bus packet receiver: front end, request queue,
// back end. Depends on sbpr_pkg, sbpr_ifs, sbpr_front, sbpr_queue, sbpr_back.
//
//   channel     dir  handshake      payload
//   item_in     in   valid/ready    mode, rx_byte, read_index
//   result_out  out  valid/ready    phase, packet_ready, active_request,
//                                   packet_kind, payload_len, in_band, read_data
//   cfg         in   valid/ready    index, data (ready is always high)
//
// One request per cycle sustained while the queue has room and the result register
// is free or draining; one result per request, loaded into the result register
// when the back end takes the request from the queue.
// Reset clears the frame state and the queue; buffer contents stay undefined.
// A stalled result holds while the two-entry queue keeps taking requests until full.
module slotted_bus_packet_receiver #(
    parameter int BUFFER_DEPTH = sbpr_pkg::BUFFER_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    sbpr_in_if.sink     item_in,
    sbpr_cfg_if.sink    cfg,
    sbpr_out_if.source  result_out
);

    logic             push_valid;
    logic             push_ready;
    sbpr_pkg::entry_t push_entry;
    logic             q_valid;
    sbpr_pkg::entry_t q_entry;
    logic             pop;

    sbpr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    sbpr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry),
        .pop        (pop)
    );

    sbpr_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule
